// File: src/clex_pkg.sv
// Package for the C subset lexer: shared token record, scanner result group
// and default sizes. No dependencies.
package clex_pkg;

  localparam int POSITION_BITS = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [4:0] K_IDENT  = 5'd0;
  localparam logic [4:0] K_NUMBER = 5'd1;
  localparam logic [4:0] K_STRING = 5'd2;
  localparam logic [4:0] K_IF     = 5'd3;
  localparam logic [4:0] K_ELSE   = 5'd4;
  localparam logic [4:0] K_WHILE  = 5'd5;
  localparam logic [4:0] K_INT    = 5'd6;
  localparam logic [4:0] K_RETURN = 5'd7;
  localparam logic [4:0] K_ASSIGN = 5'd8;
  localparam logic [4:0] K_EQ     = 5'd9;
  localparam logic [4:0] K_LT     = 5'd10;
  localparam logic [4:0] K_LE     = 5'd11;
  localparam logic [4:0] K_GT     = 5'd12;
  localparam logic [4:0] K_GE     = 5'd13;
  localparam logic [4:0] K_PLUS   = 5'd14;
  localparam logic [4:0] K_MINUS  = 5'd15;
  localparam logic [4:0] K_STAR   = 5'd16;
  localparam logic [4:0] K_SLASH  = 5'd17;
  localparam logic [4:0] K_PCT    = 5'd18;
  localparam logic [4:0] K_AMP    = 5'd19;
  localparam logic [4:0] K_LAND   = 5'd20;
  localparam logic [4:0] K_BAR    = 5'd21;
  localparam logic [4:0] K_LOR    = 5'd22;
  localparam logic [4:0] K_SEMI   = 5'd23;
  localparam logic [4:0] K_COMMA  = 5'd24;
  localparam logic [4:0] K_LPAREN = 5'd25;
  localparam logic [4:0] K_RPAREN = 5'd26;
  localparam logic [4:0] K_LBRACE = 5'd27;
  localparam logic [4:0] K_RBRACE = 5'd28;
  localparam logic [4:0] K_END    = 5'd29;
  localparam logic [4:0] K_ERR    = 5'd30;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  typedef struct packed {
    tok_t       t0;
    tok_t       t1;
    logic [1:0] count;
  } scan_res_t;

endpackage

// File: src/clex_scan.sv
// Scanner state and per-item decode: takes one byte, updates the scan
// state and returns up to two tokens. Depends on clex_pkg.
module clex_scan #(
  parameter int POSITION_BITS = clex_pkg::POSITION_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [7:0]          text_byte,
  input  logic                start_text,
  output clex_pkg::scan_res_t res
);

  typedef enum logic [3:0] {
    M_IDLE     = 4'd0,
    M_IDENT    = 4'd1,
    M_NUMBER   = 4'd2,
    M_STRING   = 4'd3,
    M_COMMENT  = 4'd4,
    M_DONE     = 4'd5,
    M_OP_EQ    = 4'd6,
    M_OP_LT    = 4'd7,
    M_OP_GT    = 4'd8,
    M_OP_AND   = 4'd9,
    M_OP_OR    = 4'd10,
    M_OP_SLASH = 4'd11
  } mode_t;

  mode_t                    mode, mode_next, cur_mode;
  logic [POSITION_BITS-1:0] pos, pos_next, cur_pos;
  logic [15:0]              pstart, pstart_next, cur_pstart;
  logic [15:0]              plen, plen_next, cur_plen;
  logic [47:0]              kw, kw_next, cur_kw;
  logic                     tl, tl_next, cur_tl;

  logic [31:0] pos32;
  logic [15:0] pos16;
  logic [15:0] grown;
  logic        is_letter, is_digit, is_blank;

  mode_t       i_mode;
  logic        i_em, i_begin, i_letter;
  logic [4:0]  i_kind;
  logic [15:0] i_len;

  logic        do_idle;
  logic        e0v;
  logic [4:0]  e0k;
  logic [15:0] e0s, e0l;
  logic        e1v;
  logic [4:0]  e1k;
  logic [15:0] e1s, e1l;
  logic [4:0]  id_kind;
  logic [7:0]  op_second;
  logic [4:0]  op_single, op_double;

  always_comb begin
    cur_mode   = start_text ? M_IDLE : mode;
    cur_pos    = start_text ? '0 : pos;
    cur_pstart = start_text ? '0 : pstart;
    cur_plen   = start_text ? '0 : plen;
    cur_kw     = start_text ? '0 : kw;
    cur_tl     = start_text ? 1'b0 : tl;
  end

  assign pos32 = 32'(cur_pos);
  assign pos16 = pos32[15:0];
  assign grown = (cur_plen == 16'hFFFF) ? cur_plen : cur_plen + 16'd1;

  assign is_letter = (text_byte >= "a" && text_byte <= "z") ||
                     (text_byte >= "A" && text_byte <= "Z") || text_byte == "_";
  assign is_digit  = text_byte >= "0" && text_byte <= "9";
  assign is_blank  = text_byte == " " || text_byte == 8'h09 || text_byte == 8'h0A;

  always_comb begin
    if (cur_tl) begin
      id_kind = clex_pkg::K_IDENT;
    end else begin
      case (cur_kw)
        48'("if"):     id_kind = clex_pkg::K_IF;
        48'("else"):   id_kind = clex_pkg::K_ELSE;
        48'("while"):  id_kind = clex_pkg::K_WHILE;
        48'("int"):    id_kind = clex_pkg::K_INT;
        48'("return"): id_kind = clex_pkg::K_RETURN;
        default:       id_kind = clex_pkg::K_IDENT;
      endcase
    end
  end

  always_comb begin
    case (cur_mode)
      M_OP_EQ: begin
        op_second = "="; op_single = clex_pkg::K_ASSIGN; op_double = clex_pkg::K_EQ;
      end
      M_OP_LT: begin
        op_second = "="; op_single = clex_pkg::K_LT; op_double = clex_pkg::K_LE;
      end
      M_OP_GT: begin
        op_second = "="; op_single = clex_pkg::K_GT; op_double = clex_pkg::K_GE;
      end
      M_OP_AND: begin
        op_second = "&"; op_single = clex_pkg::K_AMP; op_double = clex_pkg::K_LAND;
      end
      M_OP_OR: begin
        op_second = "|"; op_single = clex_pkg::K_BAR; op_double = clex_pkg::K_LOR;
      end
      default: begin
        op_second = "/"; op_single = clex_pkg::K_SLASH; op_double = clex_pkg::K_SLASH;
      end
    endcase
  end

  // outcome of a byte seen between tokens
  always_comb begin
    i_mode   = M_IDLE;
    i_em     = 1'b0;
    i_kind   = clex_pkg::K_ERR;
    i_len    = 16'd1;
    i_begin  = 1'b0;
    i_letter = 1'b0;
    if (is_blank) begin
      i_mode = M_IDLE;
    end else if (is_letter) begin
      i_mode = M_IDENT; i_begin = 1'b1; i_letter = 1'b1;
    end else if (is_digit) begin
      i_mode = M_NUMBER; i_begin = 1'b1;
    end else begin
      case (text_byte)
        "\"": begin i_mode = M_STRING;   i_begin = 1'b1; end
        "=":  begin i_mode = M_OP_EQ;    i_begin = 1'b1; end
        "<":  begin i_mode = M_OP_LT;    i_begin = 1'b1; end
        ">":  begin i_mode = M_OP_GT;    i_begin = 1'b1; end
        "&":  begin i_mode = M_OP_AND;   i_begin = 1'b1; end
        "|":  begin i_mode = M_OP_OR;    i_begin = 1'b1; end
        "/":  begin i_mode = M_OP_SLASH; i_begin = 1'b1; end
        "+":  begin i_em = 1'b1; i_kind = clex_pkg::K_PLUS;   end
        "-":  begin i_em = 1'b1; i_kind = clex_pkg::K_MINUS;  end
        "*":  begin i_em = 1'b1; i_kind = clex_pkg::K_STAR;   end
        "%":  begin i_em = 1'b1; i_kind = clex_pkg::K_PCT;    end
        ";":  begin i_em = 1'b1; i_kind = clex_pkg::K_SEMI;   end
        ",":  begin i_em = 1'b1; i_kind = clex_pkg::K_COMMA;  end
        "(":  begin i_em = 1'b1; i_kind = clex_pkg::K_LPAREN; end
        ")":  begin i_em = 1'b1; i_kind = clex_pkg::K_RPAREN; end
        "{":  begin i_em = 1'b1; i_kind = clex_pkg::K_LBRACE; end
        "}":  begin i_em = 1'b1; i_kind = clex_pkg::K_RBRACE; end
        8'h00: begin
          i_em = 1'b1; i_kind = clex_pkg::K_END; i_len = 16'd0; i_mode = M_DONE;
        end
        default: begin
          i_em = 1'b1; i_kind = clex_pkg::K_ERR; i_mode = M_DONE;
        end
      endcase
    end
  end

  always_comb begin
    mode_next   = cur_mode;
    pos_next    = cur_pos + 1'b1;
    pstart_next = cur_pstart;
    plen_next   = cur_plen;
    kw_next     = cur_kw;
    tl_next     = cur_tl;
    do_idle     = 1'b0;
    e0v = 1'b0; e0k = clex_pkg::K_IDENT; e0s = cur_pstart; e0l = cur_plen;
    e1v = 1'b0; e1k = clex_pkg::K_IDENT; e1s = pos16;      e1l = 16'd0;
    case (cur_mode)
      M_DONE: begin
        mode_next = M_DONE;
      end
      M_IDENT: begin
        if (is_letter || is_digit) begin
          plen_next = grown;
          if (grown > 16'd6) begin
            tl_next = 1'b1;
          end else begin
            kw_next = {cur_kw[39:0], text_byte};
          end
        end else begin
          e0v = 1'b1; e0k = id_kind;
          do_idle = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit) begin
          plen_next = grown;
        end else begin
          e0v = 1'b1; e0k = clex_pkg::K_NUMBER;
          do_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (text_byte == 8'h00) begin
          e0v = 1'b1; e0k = clex_pkg::K_STRING;
          e1v = 1'b1; e1k = clex_pkg::K_END;
          mode_next = M_DONE;
        end else begin
          plen_next = grown;
          if (text_byte == "\"") begin
            e0v = 1'b1; e0k = clex_pkg::K_STRING; e0l = grown;
            mode_next = M_IDLE;
          end
        end
      end
      M_COMMENT: begin
        if (text_byte == 8'h00) begin
          e1v = 1'b1; e1k = clex_pkg::K_END;
          mode_next = M_DONE;
        end else if (text_byte == 8'h0A) begin
          mode_next = M_IDLE;
        end
      end
      M_OP_EQ, M_OP_LT, M_OP_GT, M_OP_AND, M_OP_OR, M_OP_SLASH: begin
        if (text_byte == op_second) begin
          if (cur_mode == M_OP_SLASH) begin
            mode_next = M_COMMENT;
          end else begin
            e0v = 1'b1; e0k = op_double; e0l = 16'd2;
            mode_next = M_IDLE;
          end
        end else begin
          e0v = 1'b1; e0k = op_single; e0l = 16'd1;
          do_idle = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase
    if (do_idle) begin
      mode_next = i_mode;
      e1v = i_em; e1k = i_kind; e1s = pos16; e1l = i_len;
      if (i_begin) begin
        pstart_next = pos16;
        plen_next   = 16'd1;
      end
      if (i_letter) begin
        kw_next = {40'd0, text_byte};
        tl_next = 1'b0;
      end
    end
  end

  // pack emitted tokens in order, mark the final one
  always_comb begin
    res = '0;
    if (e0v) begin
      res.t0 = '{kind: e0k, start: e0s, length: e0l, last: !e1v};
      res.t1 = '{kind: e1k, start: e1s, length: e1l, last: 1'b1};
      res.count = e1v ? 2'd2 : 2'd1;
    end else if (e1v) begin
      res.t0 = '{kind: e1k, start: e1s, length: e1l, last: 1'b1};
      res.count = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      pstart <= '0;
      plen   <= '0;
      kw     <= '0;
      tl     <= 1'b0;
    end else if (go) begin
      mode   <= mode_next;
      pos    <= pos_next;
      pstart <= pstart_next;
      plen   <= plen_next;
      kw     <= kw_next;
      tl     <= tl_next;
    end
  end

endmodule

// File: src/clex_queue.sv
// Token output queue: takes up to two tokens per cycle, hands out one.
// Depends on clex_pkg.
module clex_queue #(
  parameter int DEPTH = clex_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  clex_pkg::scan_res_t res,
  input  logic                pop,
  output logic                room2,
  output logic                not_empty,
  output clex_pkg::tok_t      head
);

  localparam int AW = $clog2(DEPTH);

  clex_pkg::tok_t mem [DEPTH];
  logic [AW-1:0]  wp, rp, wp1;
  logic [AW:0]    count, count_next;
  logic [1:0]     n_in;

  assign n_in      = push ? res.count : 2'd0;
  assign wp1       = wp + 1'b1;
  assign room2     = count <= (AW+1)'(DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = mem[rp];
  assign count_next = count + (AW+1)'(n_in) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wp] <= res.t0;
    end
    if (n_in == 2'd2) begin
      mem[wp1] <= res.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + AW'(n_in);
      rp    <= rp + AW'(pop);
      count <= count_next;
    end
  end

endmodule

// File: src/c_subset_lexer.sv
// Top level of the C subset lexer: input register, scanner and token queue.
// Depends on clex_pkg, clex_scan and clex_queue.
//
// One source byte per item goes in; tokens (kind, start, length, last_of_run)
// come out. A byte is taken into an input register and decoded by the
// scanner, which advances only when the queue has room for two tokens; while
// it does, a new byte can be taken every clock. Each byte gives zero, one or
// two tokens; tokens leave through a four-entry queue at one per clock while
// token_stall is low, so the sustained rate is one byte per cycle while bytes
// average at most one token each, and the queue ports set the limit when they
// do not. Token start offsets count modulo 2^POSITION_BITS, cut to 16 bits.
module c_subset_lexer #(
  parameter int POSITION_BITS = clex_pkg::POSITION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        start_text,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  logic                a_valid;
  logic [7:0]          a_byte;
  logic                a_start;
  logic                go, room2, take, pop;
  clex_pkg::scan_res_t res;
  clex_pkg::tok_t      head;

  assign go         = a_valid && room2;
  assign text_stall = a_valid && !room2;
  assign take       = text_valid && !text_stall;
  assign pop        = token_valid && !token_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_byte  <= text_byte;
      a_start <= start_text;
    end
  end

  clex_scan #(.POSITION_BITS(POSITION_BITS)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .text_byte  (a_byte),
    .start_text (a_start),
    .res        (res)
  );

  clex_queue #(.DEPTH(clex_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (go),
    .res       (res),
    .pop       (pop),
    .room2     (room2),
    .not_empty (token_valid),
    .head      (head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

endmodule
